>>> rtl/gls_pkg.sv
package gls_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int MAX_RHS     = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC        = 16;

  localparam int COLS = MAX_ORDER + MAX_RHS;
  localparam int CW   = $clog2(COLS);
  localparam int RW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int KW   = (MAX_RHS > 1) ? $clog2(MAX_RHS) : 1;
  localparam int NW   = $clog2(MAX_ORDER + 1);
  localparam int MW   = $clog2(MAX_RHS + 1);
  localparam int PW   = 2 * VALUE_WIDTH;
  localparam int DW   = VALUE_WIDTH + FRAC;

  // operation codes
  localparam logic [1:0] OP_WR_MAT = 2'd0;
  localparam logic [1:0] OP_WR_RHS = 2'd1;
  localparam logic [1:0] OP_SOLVE  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SIZE   = 2'd0;
  localparam logic [1:0] REG_RHS    = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [COLS-1:0][VALUE_WIDTH-1:0] row_t;

  localparam val_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t ONE  = (FRAC < VALUE_WIDTH - 1) ? val_t'(64'sd1 <<< FRAC) : VMAX;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'b001,
    MODE_SUB   = 3'b010,
    MODE_SCALE = 3'b100
  } mode_t;

  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] mag;
    logic [RW-1:0]          idx;
  } best_t;

  typedef struct packed {
    logic [CW-1:0] sel_col;
    logic          issue;
    mode_t         mode;
    logic [CW-1:0] wr_col;
    val_t          wr_data;
    logic          ld_own_f;
    logic          ld_ext_f;
    val_t          f_ext;
    val_t          bus;
  } ctl_t;

  function automatic logic [VALUE_WIDTH-1:0] mag_f(input val_t a);
    mag_f = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic val_t sat_prod(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p >>> FRAC;
    if (t > PW'(VMAX)) sat_prod = VMAX;
    else if (t < PW'(VMIN)) sat_prod = VMIN;
    else sat_prod = t[VALUE_WIDTH-1:0];
  endfunction

  function automatic val_t clip1(input logic signed [VALUE_WIDTH:0] s);
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) clip1 = s[VALUE_WIDTH] ? VMIN : VMAX;
    else clip1 = s[VALUE_WIDTH-1:0];
  endfunction

  function automatic val_t add_sat(input val_t a, input val_t b);
    add_sat = clip1({a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b});
  endfunction

  function automatic val_t sub_sat(input val_t a, input val_t b);
    sub_sat = clip1({a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b});
  endfunction

  function automatic val_t neg_sat(input val_t a);
    neg_sat = (a == VMIN) ? VMAX : -a;
  endfunction

endpackage

>>> rtl/gls_div.sv
module gls_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gls_pkg::val_t     num,
  input  gls_pkg::val_t     den,
  output logic              done,
  output gls_pkg::val_t     q
);

  localparam int DW = gls_pkg::DW;
  localparam int VW = gls_pkg::VALUE_WIDTH;
  localparam int SW = $clog2(DW + 1);

  logic          busy_r, done_r, neg_r;
  logic [SW-1:0] cnt_r;
  logic [DW-1:0] dvd_r, quo_r;
  logic [VW-1:0] rem_r, ub_r;
  logic [VW:0]   rs;
  logic          fit;

  assign rs  = {rem_r, dvd_r[DW-1]};
  assign fit = rs >= {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == SW'(1));
      if (start) busy_r <= 1'b1;
      else if (busy_r && (cnt_r == SW'(1))) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {gls_pkg::mag_f(num), {gls_pkg::FRAC{1'b0}}};
      ub_r  <= gls_pkg::mag_f(den);
      rem_r <= '0;
      quo_r <= '0;
      neg_r <= num[VW-1] ^ den[VW-1];
      cnt_r <= SW'(DW);
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      rem_r <= fit ? VW'(rs - {1'b0, ub_r}) : rs[VW-1:0];
      quo_r <= {quo_r[DW-2:0], fit};
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_comb begin
    if (neg_r) begin
      if (quo_r >= DW'(gls_pkg::VMAX) + 1'b1) q = gls_pkg::VMIN;
      else q = -gls_pkg::val_t'(quo_r[VW-1:0]);
    end else begin
      if (quo_r > DW'(gls_pkg::VMAX)) q = gls_pkg::VMAX;
      else q = gls_pkg::val_t'(quo_r[VW-1:0]);
    end
  end

  assign done = done_r;

endmodule

>>> rtl/gls_cell.sv
module gls_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gls_pkg::ctl_t             ctl,
  input  logic                      en,
  input  logic                      wr,
  input  logic                      cand,
  input  logic                      swap,
  input  gls_pkg::row_t             swap_row,
  input  logic [gls_pkg::RW-1:0]    idx,
  input  gls_pkg::best_t            best_i,
  output gls_pkg::best_t            best_o,
  output gls_pkg::val_t             val,
  output gls_pkg::row_t             row
);

  gls_pkg::row_t                   row_r;
  gls_pkg::val_t                   f_r, own_r, opnd, m, newv;
  logic                            v1_r;
  logic [gls_pkg::CW-1:0]          c1_r;
  gls_pkg::mode_t                  mode1_r;
  logic signed [gls_pkg::PW-1:0]   prod, prod_r;
  gls_pkg::best_t                  best_r, best_nxt;
  logic [gls_pkg::VALUE_WIDTH-1:0] vmag;

  assign val  = gls_pkg::val_t'(row_r[ctl.sel_col]);
  assign row  = row_r;
  assign opnd = (ctl.mode == gls_pkg::MODE_SCALE) ? val : ctl.bus;
  assign prod = f_r * opnd;
  assign m    = gls_pkg::sat_prod(prod_r);
  assign vmag = gls_pkg::mag_f(val);

  always_comb begin
    case (mode1_r)
      gls_pkg::MODE_ADD: newv = gls_pkg::add_sat(own_r, m);
      gls_pkg::MODE_SUB: newv = gls_pkg::sub_sat(own_r, m);
      default:           newv = m;
    endcase
  end

  // pivot search: keep the first strictly largest magnitude down the chain
  always_comb begin
    best_nxt = best_i;
    if (cand && (!best_i.valid || vmag > best_i.mag)) begin
      best_nxt.valid = 1'b1;
      best_nxt.mag   = vmag;
      best_nxt.idx   = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      best_r <= '0;
    end else begin
      v1_r   <= ctl.issue && en;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue && en) begin
      c1_r    <= ctl.sel_col;
      mode1_r <= ctl.mode;
      prod_r  <= prod;
      own_r   <= val;
    end
    if (wr) row_r[ctl.wr_col] <= ctl.wr_data;
    else if (swap) row_r <= swap_row;
    else if (v1_r) row_r[c1_r] <= newv;
    if (ctl.ld_ext_f && en) f_r <= ctl.f_ext;
    else if (ctl.ld_own_f && en) f_r <= val;
  end

  assign best_o = best_r;

endmodule

>>> rtl/gauss_linear_solver.sv
// Gaussian elimination solver with partial pivoting, signed Q16.16.
// Input channel (in_*): one beat per item. in_tuser carries the operation:
// write a matrix entry, write a right-hand-side entry, or solve. Write beats
// are taken one per cycle while idle. A solve beat starts the elimination;
// in_tready stays low until the last result beat has been loaded into the
// output register.
// Output channel (out_*): n*m solution beats, right-hand-side column outer,
// row inner, out_tlast on the final one; or one beat with out_tuser high
// when the matrix is singular.
// Config channel (cfg_*): always ready; index 0 order, 1 rhs count,
// 2 pivot threshold. Write only while idle.
// Each pivot step runs the search chain, a swap, one divide per row below
// the pivot on the shared bit-serial divider (start, quotient bits, done),
// a row sweep column by column (all row cells work in parallel) and a
// drain. Back substitution takes one divide per row and two sweeps.
// Reset clears control state and sets order 8, one rhs, threshold 1; stored
// entries are undefined until written and after each solve.
// A stalled receiver holds the output register; the solver waits on it.
module gauss_linear_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_index[2:0], column_index[5:3],
                                  // rhs_select[7:6], entry_value[39:8]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // solution_value[31:0], out_row[34:32],
                                  // out_rhs[36:35], zero fill
  output logic        out_tuser,  // status[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int MO = gls_pkg::MAX_ORDER;
  localparam int RW = gls_pkg::RW;
  localparam int CW = gls_pkg::CW;
  localparam int KW = gls_pkg::KW;
  localparam int NW = gls_pkg::NW;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SRCH   = 14'b00000000000010,
    S_SWAP   = 14'b00000000000100,
    S_FDIV   = 14'b00000000001000,
    S_FWAIT  = 14'b00000000010000,
    S_FSWEEP = 14'b00000000100000,
    S_DRAIN  = 14'b00000001000000,
    S_BCHK   = 14'b00000010000000,
    S_BWAIT  = 14'b00000100000000,
    S_BSCALE = 14'b00001000000000,
    S_BLOADF = 14'b00010000000000,
    S_BSUB   = 14'b00100000000000,
    S_EMIT   = 14'b01000000000000,
    S_SING   = 14'b10000000000000
  } state_t;

  state_t        state_r, state_nxt, drn_r, drn_nxt;
  logic [3:0]    size_r;
  logic [2:0]    rhs_r;
  logic [30:0]   thr_r;
  logic [RW-1:0] row_r, row_nxt, i_r, i_nxt, er_r, er_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] col_r, col_nxt, col_first, col_last, col_adv;
  logic [KW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_stat_r, out_last_r;
  logic [39:0]   out_data_r;
  logic          out_free, in_acc, load_out, load_stat, load_last;
  logic [39:0]   load_data;
  int            n, m;

  gls_pkg::ctl_t  ctl;
  logic [MO-1:0]  en_v, wr_v, cand_v, swap_v;
  gls_pkg::val_t  vals [MO];
  gls_pkg::row_t  rows [MO];
  gls_pkg::best_t chain [MO+1];
  gls_pkg::best_t best;
  logic           div_start, div_done;
  gls_pkg::val_t  div_num, div_q, pv;

  logic [1:0]  in_op;
  logic [2:0]  in_row, in_col;
  logic [1:0]  in_sel;
  logic [31:0] in_val;

  assign in_op  = in_tuser;
  assign in_row = in_tdata[2:0];
  assign in_col = in_tdata[5:3];
  assign in_sel = in_tdata[7:6];
  assign in_val = in_tdata[39:8];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign best      = chain[MO];
  assign pv        = vals[row_r];

  // clamp the active order and rhs count
  always_comb begin
    n = int'(size_r);
    if (n < 1) n = 1;
    if (n > MO) n = MO;
    m = int'(rhs_r);
    if (m < 1) m = 1;
    if (m > gls_pkg::MAX_RHS) m = gls_pkg::MAX_RHS;
  end

  // column order of a sweep: matrix columns right of the pivot, then rhs
  always_comb begin
    col_first = (int'(row_r) + 1 < n) ? CW'(int'(row_r) + 1) : CW'(MO);
    col_last  = CW'(MO + m - 1);
    if (int'(col_r) < MO) col_adv = (int'(col_r) + 1 < n) ? CW'(int'(col_r) + 1) : CW'(MO);
    else col_adv = CW'(int'(col_r) + 1);
  end

  always_comb begin
    state_nxt = state_r;
    drn_nxt   = drn_r;
    row_nxt   = row_r;
    i_nxt     = i_r;
    er_nxt    = er_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    load_out  = 1'b0;
    load_stat = 1'b0;
    load_last = 1'b0;
    load_data = '0;
    div_start = 1'b0;
    div_num   = pv;
    en_v      = '0;
    wr_v      = '0;
    cand_v    = '0;
    swap_v    = '0;

    ctl          = '0;
    ctl.mode     = gls_pkg::MODE_ADD;
    ctl.sel_col  = CW'(row_r);
    ctl.bus      = pv;
    ctl.wr_data  = gls_pkg::val_t'(in_val);
    ctl.wr_col   = (in_op == gls_pkg::OP_WR_MAT) ? CW'(in_col) : CW'(MO + int'(in_sel));
    ctl.ld_ext_f = div_done;
    ctl.f_ext    = (state_r == S_FWAIT) ? gls_pkg::neg_sat(div_q) : div_q;

    for (int g = 0; g < MO; g++) begin
      cand_v[g] = (g >= int'(row_r)) && (g < n);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            gls_pkg::OP_WR_MAT: begin
              if (int'(in_row) < MO && int'(in_col) < MO) wr_v[in_row[RW-1:0]] = 1'b1;
            end
            gls_pkg::OP_WR_RHS: begin
              if (int'(in_row) < MO && int'(in_sel) < gls_pkg::MAX_RHS)
                wr_v[in_row[RW-1:0]] = 1'b1;
            end
            gls_pkg::OP_SOLVE: begin
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = (n == 1) ? S_BCHK : S_SRCH;
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (int'(cnt_r) == MO) begin
          state_nxt = (best.mag <= {1'b0, thr_r}) ? S_SING : S_SWAP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SWAP: begin
        if (best.idx != row_r) begin
          swap_v[row_r]    = 1'b1;
          swap_v[best.idx] = 1'b1;
        end
        i_nxt     = row_r + 1'b1;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        div_num   = vals[i_r];
        div_start = 1'b1;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        en_v[i_r] = 1'b1;
        if (div_done) begin
          if (int'(i_r) == n - 1) begin
            col_nxt   = col_first;
            state_nxt = S_FSWEEP;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_FDIV;
          end
        end
      end
      S_FSWEEP: begin
        ctl.issue   = 1'b1;
        ctl.sel_col = col_r;
        for (int g = 0; g < MO; g++) en_v[g] = (g > int'(row_r)) && (g < n);
        if (col_r == col_last) begin
          row_nxt   = row_r + 1'b1;
          drn_nxt   = (int'(row_r) + 2 == n) ? S_BCHK : S_SRCH;
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_adv;
        end
      end
      S_DRAIN: begin
        col_nxt   = col_first;
        state_nxt = drn_r;
      end
      S_BCHK: begin
        // zero pivot is singular even at threshold zero
        if (pv == '0 || gls_pkg::mag_f(pv) < {1'b0, thr_r}) begin
          state_nxt = S_SING;
        end else begin
          div_num   = gls_pkg::ONE;
          div_start = 1'b1;
          state_nxt = S_BWAIT;
        end
      end
      S_BWAIT: begin
        en_v[row_r] = 1'b1;
        if (div_done) begin
          col_nxt   = col_first;
          state_nxt = S_BSCALE;
        end
      end
      S_BSCALE: begin
        ctl.issue   = 1'b1;
        ctl.mode    = gls_pkg::MODE_SCALE;
        ctl.sel_col = col_r;
        en_v[row_r] = 1'b1;
        if (col_r == col_last) begin
          drn_nxt   = S_BLOADF;
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_adv;
        end
      end
      S_BLOADF: begin
        ctl.ld_own_f = 1'b1;
        for (int g = 0; g < MO; g++) en_v[g] = g < int'(row_r);
        state_nxt = S_BSUB;
      end
      S_BSUB: begin
        ctl.issue   = 1'b1;
        ctl.mode    = gls_pkg::MODE_SUB;
        ctl.sel_col = col_r;
        for (int g = 0; g < MO; g++) en_v[g] = g < int'(row_r);
        if (col_r == col_last) begin
          if (row_r == '0) begin
            drn_nxt = S_EMIT;
            k_nxt   = '0;
            er_nxt  = '0;
          end else begin
            drn_nxt = S_BCHK;
            row_nxt = row_r - 1'b1;
          end
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_adv;
        end
      end
      S_EMIT: begin
        ctl.sel_col = CW'(MO + int'(k_r));
        if (out_free) begin
          load_out  = 1'b1;
          load_last = (int'(k_r) == m - 1) && (int'(er_r) == n - 1);
          load_data = {3'b000, 2'(k_r), 3'(er_r), vals[er_r]};
          if (int'(er_r) == n - 1) begin
            er_nxt = '0;
            k_nxt  = k_r + 1'b1;
          end else begin
            er_nxt = er_r + 1'b1;
          end
          if (load_last) state_nxt = S_IDLE;
        end
      end
      S_SING: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_stat = 1'b1;
          load_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < MO; g++) begin : g_cell
    gls_pkg::row_t sw_in;
    assign sw_in = (g == int'(row_r)) ? rows[best.idx] : rows[row_r];
    gls_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .en       (en_v[g]),
      .wr       (wr_v[g]),
      .cand     (cand_v[g]),
      .swap     (swap_v[g]),
      .swap_row (sw_in),
      .idx      (RW'(g)),
      .best_i   (chain[g]),
      .best_o   (chain[g+1]),
      .val      (vals[g]),
      .row      (rows[g])
    );
  end

  assign chain[0] = '0;

  gls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (pv),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      drn_r       <= S_IDLE;
      size_r      <= 4'd8;
      rhs_r       <= 3'd1;
      thr_r       <= 31'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drn_r   <= drn_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gls_pkg::REG_SIZE:   size_r <= cfg_data[3:0];
          gls_pkg::REG_RHS:    rhs_r  <= cfg_data[2:0];
          gls_pkg::REG_THRESH: thr_r  <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    i_r   <= i_nxt;
    er_r  <= er_nxt;
    cnt_r <= cnt_nxt;
    col_r <= col_nxt;
    k_r   <= k_nxt;
    if (load_out) begin
      out_data_r <= load_data;
      out_stat_r <= load_stat;
      out_last_r <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FWAIT || state_r == S_BWAIT))
    else $error("divider finished outside a wait state");

  a_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP) |-> (best.valid && best.idx >= row_r))
    else $error("pivot row above the current step");

  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SING && out_free) |=> (state_r == S_IDLE && out_tvalid && out_tuser))
    else $error("singular status not delivered");

endmodule
